/* hdl/fpfa_pkg.sv */
// Package for the fixed partition fit allocator.
// Beat structs, op and policy codes, sequencer states. No dependencies.
package fpfa_pkg;

  localparam int CFG_W = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic        op;
    logic [1:0]  policy;
    logic [2:0]  block_index;
    logic [15:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  chosen_index;
    logic [15:0] chosen_size;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } fpfa_state_t;

endpackage

/* hdl/fixed_partition_fit_allocator.sv */
// Fixed partition fit allocator: partition size table, taken marks and the scan sequencer.
// Depends on fpfa_pkg.
//
// Load beats write one partition size and clear its taken mark; allocate beats scan the
// partitions below block_count (capped at NUM_BLOCKS) one entry per cycle through a single
// read port of the size memory and one shared compare unit, then commit the taken mark of the
// chosen entry. A load, an undefined policy or a block count of zero goes from idle straight
// to the commit state, which registers its result. An allocate steps through the scan state,
// which issues limit reads, the drain state for the registered read of the last entry, and
// the commit state, which registers the result and commits the mark; limit is the capped
// block count. The scan length is set by the one memory read per cycle. in_ready is high
// only while the sequencer is idle; a finished result waits in the output register and the
// next beat can be accepted meanwhile, but the sequencer holds in its commit state while the
// previous result is still unaccepted.
module fixed_partition_fit_allocator #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [fpfa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  fpfa_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output fpfa_pkg::out_item_t     out_data
);
  import fpfa_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  fpfa_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     block_count_r;
  logic [NUM_BLOCKS-1:0] taken_r;
  logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];

  logic [SIZE_BITS-1:0] req_r;
  logic [1:0]           pol_r;
  logic [CNT_W-1:0]     lim_r;
  logic [CNT_W-1:0]     cnt_r;

  // eval stage: registered memory read and taken mark of the entry issued last cycle
  logic                 ev_v_r;
  logic [IDX_W-1:0]     ev_idx_r;
  logic                 ev_tk_r;
  logic [SIZE_BITS-1:0] ev_size_r;

  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] pick_size_r;

  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 scan_issue;
  logic                 done_fire;
  logic                 cnt_last;
  logic                 skip_scan;
  logic [LIM_W-1:0]     lim_calc;
  logic                 cand;
  logic                 take;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_last  = (cnt_r == (lim_r - CNT_W'(1)));

  always_comb begin
    if (LIM_W'(block_count_r) > LIM_W'(NUM_BLOCKS)) begin
      lim_calc = LIM_W'(NUM_BLOCKS);
    end else begin
      lim_calc = LIM_W'(block_count_r);
    end
  end

  assign skip_scan = (in_data.op == OP_LOAD) ||
                     !(in_data.policy inside {POL_FIRST, POL_BEST, POL_WORST}) ||
                     (lim_calc == '0);

  // shared compare unit
  assign cand = !ev_tk_r && (ev_size_r >= req_r);
  always_comb begin
    take = 1'b0;
    if (ev_v_r && cand) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (pol_r)
          POL_BEST:  take = (ev_size_r < pick_size_r);
          POL_WORST: take = (ev_size_r > pick_size_r);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = skip_scan ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    done_fire  = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready   = 1'b1;
      ST_SCAN:  scan_issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  done_fire  = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else if (cfg_we) begin
      block_count_r <= cfg_wdata;
    end
  end

  // size memory: written by load beats, one read per scan cycle
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.op == OP_LOAD) && (32'(in_data.block_index) < NUM_BLOCKS)) begin
      size_mem[IDX_W'(in_data.block_index)] <= SIZE_BITS'(in_data.size_value);
    end
  end

  always_ff @(posedge clk) begin
    ev_size_r <= size_mem[cnt_r[IDX_W-1:0]];
    ev_tk_r   <= taken_r[cnt_r[IDX_W-1:0]];
    ev_idx_r  <= cnt_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
    end else if (in_fire && (in_data.op == OP_LOAD) &&
                 (32'(in_data.block_index) < NUM_BLOCKS)) begin
      taken_r[IDX_W'(in_data.block_index)] <= 1'b0;
    end else if (done_fire && found_r) begin
      taken_r[pick_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r  <= 1'b0;
      found_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      ev_v_r <= scan_issue;
      if (in_fire) begin
        found_r <= 1'b0;
        cnt_r   <= '0;
      end else begin
        if (scan_issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= SIZE_BITS'(in_data.size_value);
      pol_r <= in_data.policy;
      lim_r <= CNT_W'(lim_calc);
    end
    if (take) begin
      pick_r      <= ev_idx_r;
      pick_size_r <= ev_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data_r.granted      <= found_r;
      out_data_r.chosen_index <= found_r ? 3'(pick_r) : 3'd0;
      out_data_r.chosen_size  <= found_r ? 16'(pick_size_r) : 16'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_v_r |-> (state_r == ST_SCAN) || (state_r == ST_DRAIN))
    else $error("eval stage active outside scan");

  a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && (state_r != ST_IDLE)) |-> (pick_size_r >= req_r))
    else $error("picked partition smaller than request");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < lim_r))
    else $error("scan index beyond limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result beat not produced by done state");

endmodule
